// ===== design/fit_partition_allocator_defines.svh =====
// assertion macros for the fit partition allocator
// no dependencies; taken in by the files that carry assertions
`ifndef FIT_PARTITION_ALLOCATOR_DEFINES_SVH
`define FIT_PARTITION_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define FPA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpa check failed");

// next-cycle implication, disabled while reset is asserted
`define FPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpa check failed");

`endif

// ===== design/fpa_pkg.sv =====
// shared types and constants for the fit partition allocator
// no dependencies
`default_nettype none

package fpa_pkg;

    // table geometry
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    // fixed port widths
    localparam int BLK_W      = 4;
    localparam int FIELD_W    = 16;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

    // selection policies; any other code behaves as first fit
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_is_alloc;
        logic limit_zero;
        logic scan_last;
        logic first_hit;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== design/fpa_dpath.sv =====
// datapath: config registers, free size table, scan selection, output register
// depends on fpa_pkg
`default_nettype none

module fpa_dpath
    import fpa_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire                   i_req_type,
    input  wire [BLK_W-1:0]       i_block_index,
    input  wire [FIELD_W-1:0]     i_size_value,
    input  wire                   i_out_ready,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    output logic                  o_granted,
    output logic [BLK_W-1:0]      o_chosen_block,
    output logic [FIELD_W-1:0]    o_remaining_size
);

    logic [MODE_W-1:0]    r_fit_mode;
    logic [COUNT_W-1:0]   r_block_count;
    logic [SIZE_BITS-1:0] r_table [NUM_BLOCKS];

    logic                 r_type;
    logic [BLK_W-1:0]     r_idx;
    logic [SIZE_BITS-1:0] r_req;
    logic [IDX_W-1:0]     r_scan_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_sel_idx;
    logic [SIZE_BITS-1:0] r_sel_size;

    logic                 r_out_valid;
    logic                 r_granted;
    logic [BLK_W-1:0]     r_chosen;
    logic [FIELD_W-1:0]   r_remain;

    logic [CNT_W-1:0]     w_limit;
    logic [SIZE_BITS-1:0] w_scan_size;
    logic                 w_fits;
    logic                 w_take;
    logic                 w_first_like;
    logic                 w_load_ok;
    logic [SIZE_BITS-1:0] w_left;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode    <= MODE_FIRST;
            r_block_count <= BLOCK_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FIT_MODE:    r_fit_mode    <= i_cfg_wdata[MODE_W-1:0];
                REG_BLOCK_COUNT: r_block_count <= COUNT_W'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // partitions scanned, saturated to the table depth
    assign w_limit = (32'(r_block_count) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                        : CNT_W'(r_block_count);

    assign w_scan_size  = r_table[r_scan_idx];
    assign w_fits       = (w_scan_size >= r_req);
    assign w_first_like = (r_fit_mode != MODE_BEST) && (r_fit_mode != MODE_WORST);

    always_comb begin
        case (r_fit_mode)
            MODE_BEST:  w_take = w_fits && (!r_found || (w_scan_size <  r_sel_size));
            MODE_WORST: w_take = w_fits && (!r_found || (w_scan_size >= r_sel_size));
            default:    w_take = w_fits && !r_found;
        endcase
    end

    assign w_load_ok = (32'(r_idx) < NUM_BLOCKS);
    assign w_left    = r_sel_size - r_req;

    assign o_status.in_is_alloc = (i_req_type == REQ_ALLOC);
    assign o_status.limit_zero  = (w_limit == '0);
    assign o_status.scan_last   = ((CNT_W'(r_scan_idx) + CNT_W'(1)) == w_limit);
    assign o_status.first_hit   = w_first_like && w_fits;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    // item capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type     <= i_req_type;
            r_idx      <= i_block_index;
            r_req      <= SIZE_BITS'(i_size_value);
            r_scan_idx <= '0;
            r_found    <= 1'b0;
            r_sel_idx  <= '0;
            r_sel_size <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= r_scan_idx + IDX_W'(1);
            if (w_take) begin
                r_found    <= 1'b1;
                r_sel_idx  <= r_scan_idx;
                r_sel_size <= w_scan_size;
            end
        end
    end

    // free size table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BLOCKS; k++) begin
                r_table[k] <= '0;
            end
        end else if (i_cmd.commit) begin
            if (r_type == REQ_LOAD) begin
                if (w_load_ok) begin
                    r_table[IDX_W'(r_idx)] <= r_req;
                end
            end else if (r_found) begin
                r_table[r_sel_idx] <= w_left;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_type == REQ_LOAD) begin
                r_granted <= w_load_ok;
                r_chosen  <= w_load_ok ? r_idx : '0;
                r_remain  <= w_load_ok ? FIELD_W'(r_req) : '0;
            end else begin
                r_granted <= r_found;
                r_chosen  <= r_found ? BLK_W'(r_sel_idx) : '0;
                r_remain  <= r_found ? FIELD_W'(w_left) : '0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_granted        = r_granted;
    assign o_chosen_block   = r_chosen;
    assign o_remaining_size = r_remain;

endmodule

`default_nettype wire

// ===== design/fpa_ctrl.sv =====
// controller state machine: sequences capture, scan and commit
// depends on fpa_pkg and fit_partition_allocator_defines.svh
`default_nettype none

`include "fit_partition_allocator_defines.svh"

module fpa_ctrl
    import fpa_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  wire t_dp_status  i_status,
    output t_dp_cmd          o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.in_is_alloc && !i_status.limit_zero) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_COMMIT;
                    end
                end
            end
            ST_SCAN: begin
                if (i_status.first_hit || i_status.scan_last) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.commit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_COMMIT: begin
                o_cmd.commit = i_status.out_free;
            end
            default: ;
        endcase
    end

    `FPA_ASSERT_SAME(a_commit_needs_slot, i_clk, i_rst_n, o_cmd.commit, i_status.out_free)
    `FPA_ASSERT_NEXT(a_alloc_starts_scan, i_clk, i_rst_n,
        o_cmd.capture && i_status.in_is_alloc && !i_status.limit_zero, r_state == ST_SCAN)
    `FPA_ASSERT_NEXT(a_scan_continues, i_clk, i_rst_n,
        o_cmd.scan_step && !i_status.first_hit && !i_status.scan_last, r_state == ST_SCAN)

endmodule

`default_nettype wire

// ===== design/fit_partition_allocator.sv =====
// top level of the fit partition allocator: controller plus datapath
// depends on fpa_pkg, fpa_ctrl and fpa_dpath
//
// usage
// - input channel (i_in_valid / o_in_ready) carries one item: a load writes
//   i_size_value into partition i_block_index, an allocate asks for
//   i_size_value units from a partition chosen by the fit mode
// - output channel (o_out_valid / i_out_ready) returns exactly one item per
//   input item: granted flag, partition and its free size afterwards
// - config port (i_cfg_we, i_cfg_index, i_cfg_wdata) writes fit_mode (index 0)
//   or block_count (index 1); write only while the block is idle
// - items are handled one at a time; ready is high only while idle
// - a load goes from accept straight to commit; an allocate first scans n
//   partitions (block_count, saturated to 16, fewer for first fit when a
//   match turns up early) and then commits
// - the scan reads one table entry per cycle, which sets the rate
// - a stalled receiver holds the result in the output register; the next
//   item may be accepted meanwhile, and its commit waits for the slot
// - reset clears the table to zero, fit_mode to first fit, block_count to 16
`default_nettype none

module fit_partition_allocator
    import fpa_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire                   i_req_type,
    input  wire [BLK_W-1:0]       i_block_index,
    input  wire [FIELD_W-1:0]     i_size_value,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic                  o_granted,
    output logic [BLK_W-1:0]      o_chosen_block,
    output logic [FIELD_W-1:0]    o_remaining_size
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    fpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    fpa_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_req_type       (i_req_type),
        .i_block_index    (i_block_index),
        .i_size_value     (i_size_value),
        .i_out_ready      (i_out_ready),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_out_valid      (o_out_valid),
        .o_granted        (o_granted),
        .o_chosen_block   (o_chosen_block),
        .o_remaining_size (o_remaining_size)
    );

endmodule

`default_nettype wire
